### design/sliding_window_max_assert.svh
// Assertion macros shared by the sliding window maximum design.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef SLIDING_WINDOW_MAX_ASSERT_SVH
`define SLIDING_WINDOW_MAX_ASSERT_SVH

// Condition that must hold at every clock edge.
`define SWM_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SWM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### design/swm_pkg.sv
`default_nettype none

package swm_pkg;

	localparam int WIN_MAX  = 64;
	localparam int SAMPLE_W = 32;
	localparam int PTR_W    = $clog2(WIN_MAX);
	localparam int POS_W    = PTR_W + 1;
	localparam int WIN_W    = 7;
	localparam int PADDR_W  = 3;

	// Register indexes of the configuration port
	localparam logic REG_WINDOW_SIZE = 1'b0;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd3;

	typedef logic [PTR_W-1:0]           ptr_t;
	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [WIN_W-1:0]           win_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// One deque entry: value and its position tag
	typedef struct packed {
		pos_t    pos;
		sample_t val;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FRONT = 4'b0010,
		ST_BACK  = 4'b0100,
		ST_HOLD  = 4'b1000
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;
		logic front_pop;
		logic front_keep;
		logic back_pop;
		logic append;
		logic rd_back;
		logic load_direct;
		logic load_held;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic count_zero;
		logic front_old;
		logic back_smaller;
		logic emit;
		logic out_free;
	} sts_t;

	// Clamp the programmed window size into 1..WIN_MAX
	function automatic win_t eff_window(input win_t w);
		win_t r;
		r = w;
		if (w == '0) begin
			r = win_t'(1);
		end else if (w > win_t'(WIN_MAX)) begin
			r = win_t'(WIN_MAX);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/swm_ctrl.sv
`default_nettype none

module swm_ctrl
	import swm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// Sequence one item: age eviction, back pops, append and result hand-off
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FRONT;
				end
			end
			ST_FRONT: begin
				if (!sts.count_zero && sts.front_old) begin
					cmd.front_pop = 1'b1;
				end else begin
					cmd.front_keep = 1'b1;
					cmd.rd_back    = 1'b1;
					state_d        = ST_BACK;
				end
			end
			ST_BACK: begin
				if (!sts.count_zero && sts.back_smaller) begin
					cmd.back_pop = 1'b1;
					cmd.rd_back  = 1'b1;
				end else begin
					cmd.append = 1'b1;
					if (!sts.emit) begin
						state_d = ST_IDLE;
					end else if (sts.out_free) begin
						cmd.load_direct = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (sts.out_free) begin
					cmd.load_held = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### design/swm_datapath.sv
`default_nettype none
`include "sliding_window_max_assert.svh"

module swm_datapath
	import swm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	input  wire logic [SAMPLE_W-1:0] in_sample,
	input  wire logic                in_start,
	input  wire logic                cfg_wr,
	input  wire logic [PADDR_W-1:0]  cfg_addr,
	input  wire logic [31:0]         cfg_wdata,
	output logic [31:0]              cfg_rdata,
	input  wire logic                out_ready,
	output logic                     out_valid,
	output logic [SAMPLE_W-1:0]      out_data
);

	entry_t        mem [WIN_MAX];
	entry_t        rd_q;
	ptr_t          rd_addr;

	win_t          win_q;
	win_t          ews;
	win_t          ews_q;
	ptr_t          head_q, head_d;
	ptr_t          tail_q, tail_d;
	logic [PTR_W:0] count_q, count_d;
	pos_t          position_q;
	pos_t          pos_base;
	pos_t          pos_q;
	win_t          filled_q;
	win_t          fill_base, fill_clamp, fill_next;
	logic          emit_q;
	sample_t       sample_q;
	sample_t       front_q;
	sample_t       res_d, res_q;
	sample_t       out_q;
	logic          out_valid_q;
	pos_t          age;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WINDOW_RESET;
		end else if (cfg_wr && (cfg_addr[2] == REG_WINDOW_SIZE)) begin
			win_q <= cfg_wdata[WIN_W-1:0];
		end
	end

	assign cfg_rdata = (cfg_addr[2] == REG_WINDOW_SIZE) ? {{(32-WIN_W){1'b0}}, win_q} : '0;
	assign ews       = eff_window(win_q);

	// Sequence bookkeeping on the incoming transaction
	assign pos_base   = in_start ? '0 : position_q;
	assign fill_base  = in_start ? '0 : filled_q;
	assign fill_clamp = (fill_base > ews) ? ews : fill_base;
	assign fill_next  = (fill_clamp < ews) ? win_t'(fill_clamp + win_t'(1)) : fill_clamp;

	// Next deque pointers
	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		if (cmd.accept && in_start) begin
			head_d  = '0;
			tail_d  = '0;
			count_d = '0;
		end
		if (cmd.front_pop) begin
			head_d  = ptr_t'(head_q + ptr_t'(1));
			count_d = count_q - (PTR_W+1)'(1);
		end
		if (cmd.back_pop) begin
			tail_d  = ptr_t'(tail_q - ptr_t'(1));
			count_d = count_q - (PTR_W+1)'(1);
		end
		if (cmd.append) begin
			tail_d  = ptr_t'(tail_q + ptr_t'(1));
			count_d = count_q + (PTR_W+1)'(1);
		end
	end

	assign rd_addr = cmd.rd_back ? ptr_t'(tail_d - ptr_t'(1)) : head_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			position_q <= '0;
			filled_q   <= '0;
			emit_q     <= 1'b0;
		end else begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (cmd.accept) begin
				position_q <= pos_t'(pos_base + pos_t'(1));
				filled_q   <= fill_next;
				emit_q     <= (fill_next >= ews);
			end
		end
	end

	// Hold the item under work
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample_t'(in_sample);
			pos_q    <= pos_base;
			ews_q    <= ews;
		end
	end

	// Deque memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem[tail_q] <= '{pos: pos_q, val: sample_q};
		end
		rd_q <= mem[rd_addr];
	end

	// Compare the entry just read
	assign age              = pos_t'(pos_q - rd_q.pos);
	assign sts.count_zero   = (count_q == '0);
	assign sts.front_old    = (age >= ews_q);
	assign sts.back_smaller = (sample_q > rd_q.val);
	assign sts.emit         = emit_q;
	assign sts.out_free     = !out_valid_q || out_ready;

	// Front survivor and result
	assign res_d = (count_q == '0) ? sample_q : front_q;

	always_ff @(posedge clk) begin
		if (cmd.front_keep) begin
			front_q <= rd_q.val;
		end
		if (cmd.append) begin
			res_q <= res_d;
		end
		if (cmd.load_direct) begin
			out_q <= res_d;
		end else if (cmd.load_held) begin
			out_q <= res_q;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_direct || cmd.load_held) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SWM_ASSERT_ALWAYS(a_count_bound, count_q <= (PTR_W+1)'(WIN_MAX), "deque count overflow")
	`SWM_ASSERT_ALWAYS(a_count_ptrs, count_q[PTR_W-1:0] == ptr_t'(tail_q - head_q), "count mismatch")
	`SWM_ASSERT_IMPL(a_pop_nonempty, cmd.back_pop || cmd.front_pop, count_q != '0, "pop from empty deque")
	`SWM_ASSERT_IMPL(a_load_free, cmd.load_direct || cmd.load_held, !out_valid_q || out_ready, "output overrun")

endmodule

`default_nettype wire

### design/sliding_window_max.sv
// Sliding window maximum over a stream of signed 32-bit samples.
// Input channel s_*: one sample per transaction, s_tuser marks the first sample of a new
// sequence and clears the window. Output channel m_*: one maximum per sample once the
// sequence holds at least window_size samples; earlier samples give no transaction.
// window_size is written over the APB port at byte address 0 (reset 3, clamped to 1..64);
// the user must write it only while the block is idle, which the block itself does not enforce.
// An item passes through the IDLE, FRONT and BACK states, and FRONT or BACK repeats for each
// deque entry dropped from the front (aged out) or from the back (smaller than the new sample).
// Each entry is pushed once and dropped at most once. The pace is set by the single read port
// of the 64-entry deque memory, one entry examined per cycle; no new sample is taken until IDLE.
// The result appears in m_tdata at the clock edge that completes the item; when nothing is
// dropped and the output register is free, that is the edge that ends the BACK state.
// Reset clears the deque, the position and fill counts and the output valid flag; the deque
// memory needs no clearing pass.
// When the receiver stalls, the result waits in the output register and the next sample is
// still accepted and worked on; its result waits inside until the register frees, and no
// further sample is taken meanwhile.
`default_nettype none

module sliding_window_max
	import swm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
	input  wire logic                s_tuser,   // [0] start_req
	// output stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [SAMPLE_W-1:0]      m_tdata,   // [31:0] window_max
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	// Write on the access phase of an APB transaction
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_sample (s_tdata),
		.in_start  (s_tuser),
		.cfg_wr    (cfg_wr),
		.cfg_addr  (paddr),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire
